@@ hdl/asra_pkg.sv @@
// Shared types and constants for the ADC scan block with rolling average.
`timescale 1ns / 1ps

package asra_pkg;

    // shared divider geometry
    localparam int DIV_W       = 32;
    localparam int DSR_W       = 17;
    localparam int DIV_STEP    = 2;
    localparam int DIV_CYCLES  = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // scan channels
    localparam logic [4:0] CH_BATTERY = 5'd1;
    localparam logic [4:0] CH_VOX     = 5'd3;
    localparam logic [4:0] CH_TEMP    = 5'd26;

    // arithmetic constants
    localparam logic [DIV_W-1:0] TEMP_SCALE = 32'd1000000;
    localparam logic [DSR_W-1:0] TEMP_DIV   = 17'd100000;
    localparam logic [DSR_W-1:0] BATT_DIV   = 17'd416;
    localparam logic [DIV_W-1:0] BATT_ROUND = 32'd208;

    // config register indexes
    localparam logic [1:0] REG_AVG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TEMP_OFFSET = 2'd1;
    localparam logic [1:0] REG_TEMP_CAL    = 2'd2;

    // config reset values
    localparam logic [9:0]        RST_AVG_LIMIT   = 10'd250;
    localparam logic [13:0]       RST_TEMP_OFFSET = 14'd9250;
    localparam logic signed [7:0] RST_TEMP_CAL    = 8'sd0;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/asra_div.sv @@
// Shared iterative unsigned divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module asra_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asra_pkg::t_div_req i_req,
    output asra_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [asra_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [asra_pkg::DSR_W-1:0]     r_rem;
    logic [asra_pkg::DSR_W-1:0]     r_dsr;
    logic [asra_pkg::DIV_W-1:0]     r_quo;
    logic [asra_pkg::DSR_W-1:0]     n_rem;
    logic [asra_pkg::DIV_W-1:0]     n_quo;

    // restoring steps: remainder shifts in dividend bits from the top of r_quo
    always_comb begin
        logic [asra_pkg::DSR_W-1:0] rem;
        logic [asra_pkg::DIV_W-1:0] quo;
        logic [asra_pkg::DSR_W:0]   sh;
        rem = r_rem;
        quo = r_quo;
        sh  = '0;
        for (int k = 0; k < asra_pkg::DIV_STEP; k++) begin
            sh  = {rem, quo[asra_pkg::DIV_W-1]};
            quo = {quo[asra_pkg::DIV_W-2:0], 1'b0};
            if (sh >= {1'b0, r_dsr}) begin
                sh     = sh - {1'b0, r_dsr};
                quo[0] = 1'b1;
            end
            rem = sh[asra_pkg::DSR_W-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == asra_pkg::DIV_CNT_W'(asra_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(r_busy) && r_cnt == '0) |-> ##(asra_pkg::DIV_CYCLES) r_done)
        else $error("divider did not finish in the fixed cycle count");
`endif

endmodule

@@ hdl/adc_scan_with_rolling_average.sv @@
// Top level: ADC scan sequencer with rolling temperature average and result formatting.
`timescale 1ns / 1ps

// Each input transaction is either a conversion result (tuser = 0) for the channel
// currently being converted, or a channel override (tuser = 1). The scan steps
// battery (1), VOX (3), temperature (26), back to battery; results on any other
// channel are dropped without advancing. Every input transaction produces exactly
// one output transaction with the next channel, battery voltage times ten, raw VOX
// level, temperature value and the current averaging length. One item is worked on
// at a time and s_axis_tready is low meanwhile. All division goes through one
// shared 32-by-17-bit divider that retires two quotient bits per cycle. From
// acceptance to result: override, VOX and unknown channel go straight to the finish
// state; battery takes one divide by 416; temperature takes a scale multiply, then
// avg/len, sample/len and avg/100000 on the divider. A finished result waits in
// the output register, and the next item is taken while it waits. Config writes
// are always accepted and must only be issued while the block is idle.

module adc_scan_with_rolling_average #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] sample, [16:12] channel, rest zero
    input  logic        s_axis_tuser,   // [0] kind
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [4:0] next_channel, [11:5] battery_tenths,
                                        // [23:12] vox_level, [39:24] temperature_value,
                                        // [49:40] average_count, rest zero
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BATT   = 4'd1;
    localparam logic [3:0] S_BATT_W = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_TLEN   = 4'd4;
    localparam logic [3:0] S_D1     = 4'd5;
    localparam logic [3:0] S_D1_W   = 4'd6;
    localparam logic [3:0] S_D2     = 4'd7;
    localparam logic [3:0] S_D2_W   = 4'd8;
    localparam logic [3:0] S_D3     = 4'd9;
    localparam logic [3:0] S_D3_W   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // config registers
    logic [9:0]        r_limit;
    logic [13:0]       r_offset;
    logic signed [7:0] r_cal;

    // scan state
    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic [4:0]             r_cur_ch;
    logic [SAMPLE_BITS-1:0] r_batt_raw;
    logic [SAMPLE_BITS-1:0] r_vox_raw;
    logic [SAMPLE_BITS-1:0] r_samp;
    logic [31:0]            r_avg;
    logic [9:0]             r_len;
    logic [31:0]            r_s;        // scaled temperature sample
    logic [31:0]            r_tmp;      // avg / len
    logic [6:0]             r_batt_tenths;
    logic [15:0]            r_avg_q;    // avg / 100000

    // output register
    logic        r_m_valid;
    logic [55:0] r_m_data;

    // divider link
    asra_pkg::t_div_req w_div_req;
    asra_pkg::t_div_rsp w_div_rsp;

    logic                   w_in_acc;
    logic                   w_kind;
    logic [SAMPLE_BITS-1:0] w_smp;
    logic [4:0]             w_ch;
    logic [9:0]             w_lim;
    logic                   w_out_free;

    // temperature formatting
    logic signed [17:0] w_cal18;
    logic signed [17:0] w_cal10;
    logic signed [17:0] w_t_full;
    logic signed [17:0] w_t_half;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_kind     = s_axis_tuser;
    assign w_smp      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_ch       = s_axis_tdata[16:12];
    assign w_lim      = (r_limit == 10'd0) ? 10'd1 : r_limit;
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= asra_pkg::RST_AVG_LIMIT;
            r_offset <= asra_pkg::RST_TEMP_OFFSET;
            r_cal    <= asra_pkg::RST_TEMP_CAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                asra_pkg::REG_AVG_LIMIT:   r_limit  <= i_cfg_data[9:0];
                asra_pkg::REG_TEMP_OFFSET: r_offset <= i_cfg_data;
                asra_pkg::REG_TEMP_CAL:    r_cal    <= $signed(i_cfg_data[7:0]);
                default: ;
            endcase
        end
    end

    // divider request, muxed by sequencer state
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            S_BATT: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = (32'(r_batt_raw) << 3) + (32'(r_batt_raw) << 1)
                                   + asra_pkg::BATT_ROUND;
                w_div_req.divisor  = asra_pkg::BATT_DIV;
            end
            S_D1: begin
                w_div_req.start    = (r_len != 10'd0);
                w_div_req.dividend = r_avg;
                w_div_req.divisor  = 17'(r_len);
            end
            S_D2: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_s;
                w_div_req.divisor  = 17'(r_len);
            end
            S_D3: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_avg;
                w_div_req.divisor  = asra_pkg::TEMP_DIV;
            end
            default: ;
        endcase
    end

    asra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_kind) begin
                        n_state = S_DONE;
                    end else begin
                        case (r_cur_ch)
                            asra_pkg::CH_BATTERY: n_state = S_BATT;
                            asra_pkg::CH_TEMP:    n_state = S_MUL;
                            default:              n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_BATT:   n_state = S_BATT_W;
            S_BATT_W: if (w_div_rsp.done) n_state = S_DONE;
            S_MUL:    n_state = S_TLEN;
            S_TLEN:   n_state = S_D1;
            // a zero length leaves the average as set; not reachable in practice
            S_D1:     n_state = (r_len == 10'd0) ? S_D3 : S_D1_W;
            S_D1_W:   if (w_div_rsp.done) n_state = S_D2;
            S_D2:     n_state = S_D2_W;
            S_D2_W:   if (w_div_rsp.done) n_state = S_D3;
            S_D3:     n_state = S_D3_W;
            S_D3_W:   if (w_div_rsp.done) n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur_ch      <= asra_pkg::CH_BATTERY;
            r_batt_raw    <= '0;
            r_vox_raw     <= '0;
            r_avg         <= '0;
            r_len         <= '0;
            r_batt_tenths <= '0;
            r_avg_q       <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            // result loads when the output register is free, else drains on tready
            if (r_state == S_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_kind) begin
                            r_cur_ch <= w_ch;
                        end else begin
                            case (r_cur_ch)
                                asra_pkg::CH_BATTERY: begin
                                    r_batt_raw <= w_smp;
                                    r_cur_ch   <= asra_pkg::CH_VOX;
                                end
                                asra_pkg::CH_VOX: begin
                                    r_vox_raw <= w_smp;
                                    r_cur_ch  <= asra_pkg::CH_TEMP;
                                end
                                asra_pkg::CH_TEMP: begin
                                    r_cur_ch <= asra_pkg::CH_BATTERY;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_BATT_W: begin
                    if (w_div_rsp.done) begin
                        r_batt_tenths <= w_div_rsp.quotient[6:0];
                    end
                end
                S_TLEN: begin
                    // first sample seeds the average; length grows to the limit
                    if (r_len == 10'd0) begin
                        r_avg <= r_s;
                    end
                    if (r_len < w_lim) begin
                        r_len <= r_len + 10'd1;
                    end
                end
                S_D2_W: begin
                    if (w_div_rsp.done) begin
                        r_avg <= r_avg - r_tmp + w_div_rsp.quotient;
                    end
                end
                S_D3_W: begin
                    if (w_div_rsp.done) begin
                        r_avg_q <= w_div_rsp.quotient[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_samp <= w_smp;
        end
        if (r_state == S_MUL) begin
            r_s <= 32'(r_samp) * asra_pkg::TEMP_SCALE;
        end
        if (r_state == S_D1_W && w_div_rsp.done) begin
            r_tmp <= w_div_rsp.quotient;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_m_data <= {6'd0, r_len, w_t_half[15:0], 12'(r_vox_raw),
                         r_batt_tenths, r_cur_ch};
        end
    end

    // temperature: (offset + 10*cal - avg/100000) / 2, rounded toward zero
    assign w_cal18  = 18'(r_cal);
    assign w_cal10  = (w_cal18 <<< 3) + (w_cal18 <<< 1);
    assign w_t_full = $signed({4'd0, r_offset}) + w_cal10 - $signed({2'd0, r_avg_q});
    assign w_t_half = (w_t_full + $signed({17'd0, w_t_full[17]})) >>> 1;

`ifndef ASSERT_OFF
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_BATT_W || r_state == S_D1_W ||
                            r_state == S_D2_W || r_state == S_D3_W))
        else $error("divider result arrived with no one waiting");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D1) |-> (r_len != 10'd0))
        else $error("averaging length zero after temperature update");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the finish state");
    a_temp_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cur_ch == asra_pkg::CH_BATTERY))
        else $error("scan did not return to battery after temperature");
`endif

endmodule

@@ bench/asra_reading_check.sv @@
// Reading checker for the ADC scan block: mirrors its state and checks each output transaction.
`timescale 1ns / 1ps

module asra_reading_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_reading_count,
    output int          o_temp_count,
    output int          o_ignored_count,
    output int          o_longest_average
);

    typedef struct packed {
        logic [4:0]         next_channel;
        logic [6:0]         battery_tenths;
        logic [11:0]        vox_level;
        logic signed [15:0] temperature_value;
        logic [9:0]         average_count;
    } t_scan_reading;

    // register copies
    logic [9:0]        limit_q;
    logic [13:0]       offset_q;
    logic signed [7:0] cal_q;

    // scan state copies
    logic [4:0]  chan_q;
    logic [11:0] batt_q;
    logic [11:0] vox_q;
    logic [31:0] avg_q;
    logic [9:0]  len_q;

    t_scan_reading readings_due[$];

    int mismatch_n = 0;
    int temp_n     = 0;
    int ignored_n  = 0;
    int longest_n  = 0;

    assign o_fail_count      = mismatch_n;
    assign o_temp_count      = temp_n;
    assign o_ignored_count   = ignored_n;
    assign o_longest_average = longest_n;

    // growing average: seed on first sample, then avg - avg/len + s/len
    task automatic fold_temperature(input logic [11:0] smp);
        logic [9:0]  lim;
        logic [31:0] scaled;
        lim    = (limit_q == 10'd0) ? 10'd1 : limit_q;
        scaled = 32'(smp) * asra_pkg::TEMP_SCALE;
        if (len_q == 10'd0) avg_q = scaled;
        if (len_q < lim) len_q = len_q + 10'd1;   // lowered limit: length just holds
        avg_q = avg_q - avg_q / 32'(len_q) + scaled / 32'(len_q);
        if (int'(len_q) > longest_n) longest_n = int'(len_q);
    endtask

    task automatic advance_scan(input logic kind, input logic [11:0] smp,
                                input logic [4:0] ch);
        if (kind) begin
            chan_q = ch;
        end else if (chan_q == asra_pkg::CH_BATTERY) begin
            batt_q = smp;
            chan_q = asra_pkg::CH_VOX;
        end else if (chan_q == asra_pkg::CH_VOX) begin
            vox_q  = smp;
            chan_q = asra_pkg::CH_TEMP;
        end else if (chan_q == asra_pkg::CH_TEMP) begin
            fold_temperature(smp);
            temp_n++;
            chan_q = asra_pkg::CH_BATTERY;
        end else begin
            ignored_n++;
        end
    endtask

    function automatic t_scan_reading present_reading();
        t_scan_reading r;
        logic [31:0]   tenths;
        int            t;
        tenths = (32'(batt_q) * 32'd10 + asra_pkg::BATT_ROUND) / 32'(asra_pkg::BATT_DIV);
        t = int'(offset_q) + int'(cal_q) * 10 - int'(avg_q / 32'(asra_pkg::TEMP_DIV));
        r.next_channel      = chan_q;
        r.battery_tenths    = tenths[6:0];
        r.vox_level         = vox_q;
        r.temperature_value = 16'(t / 2);        // int division truncates toward zero
        r.average_count     = len_q;
        return r;
    endfunction

    function automatic void compare_field(input string field, input int want, input int have);
        if (want != have) begin
            mismatch_n++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, have);
        end
    endfunction

    always @(posedge i_clk) begin
        t_scan_reading due;
        if (!i_rst_n) begin
            limit_q  = asra_pkg::RST_AVG_LIMIT;
            offset_q = asra_pkg::RST_TEMP_OFFSET;
            cal_q    = asra_pkg::RST_TEMP_CAL;
            chan_q   = asra_pkg::CH_BATTERY;
            batt_q   = '0;
            vox_q    = '0;
            avg_q    = '0;
            len_q    = '0;
            readings_due.delete();
            o_reading_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    asra_pkg::REG_AVG_LIMIT:   limit_q  = i_cfg_data[9:0];
                    asra_pkg::REG_TEMP_OFFSET: offset_q = i_cfg_data;
                    asra_pkg::REG_TEMP_CAL:    cal_q    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_scan(i_s_tuser, i_s_tdata[11:0], i_s_tdata[16:12]);
                readings_due.push_back(present_reading());
            end
            if (i_m_tvalid && i_m_tready) begin
                o_reading_count <= o_reading_count + 1;
                if (readings_due.size() == 0) begin
                    mismatch_n++;
                    $display("%0t: output transaction with nothing expected, expected none, actual %h",
                             $time, i_m_tdata);
                end else begin
                    due = readings_due.pop_front();
                    compare_field("next_channel", due.next_channel, i_m_tdata[4:0]);
                    compare_field("battery_tenths", due.battery_tenths, i_m_tdata[11:5]);
                    compare_field("vox_level", due.vox_level, i_m_tdata[23:12]);
                    compare_field("temperature_value", int'(due.temperature_value),
                                  int'($signed(i_m_tdata[39:24])));
                    compare_field("average_count", due.average_count, i_m_tdata[49:40]);
                    compare_field("tdata padding", 0, i_m_tdata[55:50]);
                end
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top: drives the ADC scan block, programs its registers and reports the verdict.
`timescale 1ns / 1ps

// Stimulus runs in three idle modes: sender idles 13% / receiver stalls 51%,
// then swapped, then no idling at all. A short directed sweep comes first,
// then six random phases, each behind a fresh register setting written only
// once every expected reading has come back.
module tb_top;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 134;   // about 800 random items in all
    localparam int DRAIN_CYCLES = 70;    // longest path is the temperature update

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [11:0] sample, [16:12] channel, rest zero
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [4:0] next_channel, [11:5] battery_tenths,
                                 // [23:12] vox_level, [39:24] temperature_value,
                                 // [49:40] average_count, rest zero
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [13:0] i_cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int directed_items;

    int fail_count;
    int reading_count;
    int temp_count;
    int ignored_count;
    int longest_average;

    adc_scan_with_rolling_average uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    asra_reading_check u_reading_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tuser         (s_axis_tuser),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_reading_count   (reading_count),
        .o_temp_count      (temp_count),
        .o_ignored_count   (ignored_count),
        .o_longest_average (longest_average)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("adc_scan_with_rolling_average test failed");
        $finish;
    end

    // Receiver: one tready decision per edge.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One input transaction. tvalid stays high afterwards so back-to-back
    // items never see a low/high pair in the same step.
    task automatic send_item(input logic kind, input logic [11:0] smp, input logic [4:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, ch, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Mostly clean scans with random samples; a few overrides, some to dead channels.
    task automatic send_random_item();
        int          pick;
        logic        kind;
        logic [11:0] smp;
        logic [4:0]  ch;
        pick = $urandom_range(99);
        kind = 1'b0;
        smp  = 12'($urandom_range(4095));
        ch   = 5'($urandom_range(31));
        if (pick < 7) begin
            kind = 1'b1;
            case ($urandom_range(2))
                0:       ch = asra_pkg::CH_BATTERY;
                1:       ch = asra_pkg::CH_VOX;
                default: ch = asra_pkg::CH_TEMP;
            endcase
        end else if (pick < 10) begin
            kind = 1'b1;
        end
        if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 12'hFFF : 12'h000;
        send_item(kind, smp, ch);
    endtask

    // Drop tvalid and wait until every reading has come back.
    task automatic wait_all_readings();
        s_axis_tvalid <= 1'b0;
        while (reading_count != items_sent) @(posedge i_clk);
    endtask

    // Writes all three registers back to back, valid held high throughout.
    task automatic program_settings(input logic [9:0] lim, input logic [13:0] off,
                                    input logic [7:0] cal);
        logic [13:0] vals [3];
        logic [1:0]  regs [3];
        vals[0] = 14'(lim);
        vals[1] = off;
        vals[2] = 14'(cal);
        regs[0] = asra_pkg::REG_AVG_LIMIT;
        regs[1] = asra_pkg::REG_TEMP_OFFSET;
        regs[2] = asra_pkg::REG_TEMP_CAL;
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(1'b0, 12'h000, 5'd31);       // battery zero; channel field ignored
        send_item(1'b0, 12'hFFF, 5'd0);        // VOX full scale
        send_item(1'b0, 12'hFFF, 5'd0);        // first temperature sample seeds average at top
        send_item(1'b0, 12'hFFF, 5'd31);       // battery full scale
        send_item(1'b0, 12'h000, 5'd0);        // VOX zero
        send_item(1'b0, 12'h000, 5'd0);        // temperature zero pulls average down
        send_item(1'b1, 12'hFFF, 5'd0);        // override to channel 0, sample ignored
        send_item(1'b0, 12'hABC, asra_pkg::CH_TEMP);     // unknown channel: dropped, no advance
        send_item(1'b1, 12'h000, 5'd31);       // override to channel 31
        send_item(1'b0, 12'hFFF, asra_pkg::CH_BATTERY);  // still dropped
        send_item(1'b1, 12'h555, asra_pkg::CH_TEMP);     // jump straight to temperature
        send_item(1'b0, 12'h800, 5'd0);
        send_item(1'b1, 12'h000, asra_pkg::CH_VOX);
        send_item(1'b0, 12'h7FF, 5'd0);
        send_item(1'b1, 12'hAAA, asra_pkg::CH_BATTERY);
        send_item(1'b1, 12'h000, asra_pkg::CH_BATTERY);  // override to the channel already selected
        send_item(1'b0, 12'h001, 5'd0);
        send_item(1'b0, 12'h555, 5'd21);
        send_item(1'b0, 12'hAAA, 5'd10);
        send_item(1'b1, 12'h000, 5'd5);        // another dead channel
        send_item(1'b0, 12'h123, 5'd0);
        send_item(1'b1, 12'h000, asra_pkg::CH_BATTERY);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= asra_pkg::REG_AVG_LIMIT;
        i_cfg_data    <= '0;
        send_idle_pct  = 13;
        recv_stall_pct = 51;
        items_sent     = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sweep on reset settings
        run_directed();
        directed_items = items_sent;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct  = 51;
                recv_stall_pct = 13;
            end
            if (phase == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            wait_all_readings();
            case (phase)
                // widest limit, offset and most negative calibration
                0: program_settings(10'd1023, 14'd16383, 8'h80);
                // zero limit acts as one; length built above stays put
                1: program_settings(10'd0, 14'd0, 8'h7F);
                2: program_settings(10'd3, 14'($urandom_range(16383)),
                                    8'($urandom_range(255)));
                3: program_settings(asra_pkg::RST_AVG_LIMIT, asra_pkg::RST_TEMP_OFFSET,
                                    asra_pkg::RST_TEMP_CAL);
                4: program_settings(10'($urandom_range(1000, 1)),
                                    14'($urandom_range(16383)), 8'($urandom_range(255)));
                default: program_settings(10'd1, 14'($urandom_range(16383)),
                                          8'($urandom_range(255)));
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        wait_all_readings();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed), %0d readings checked over %0d settings phases.",
                 items_sent, directed_items, reading_count, PHASES);
        $display("Temperature samples %0d, dropped conversions %0d, longest average %0d.",
                 temp_count, ignored_count, longest_average);
        if (fail_count == 0 && reading_count == items_sent) begin
            $display("adc_scan_with_rolling_average test passed");
        end else begin
            $display("adc_scan_with_rolling_average test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/asra_pkg.sv
hdl/asra_div.sv
hdl/adc_scan_with_rolling_average.sv
bench/asra_reading_check.sv
bench/tb_top.sv
